// ===== rtl/core/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; every other file of the block uses this package.
package ple_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int LEN_W = 8;

    typedef enum logic [2:0] {
        MODE_INS_END   = 3'd0,
        MODE_INS_FRONT = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_END   = 3'd3,
        MODE_DEL_FRONT = 3'd4,
        MODE_DEL_POS   = 3'd5,
        MODE_READ      = 3'd6,
        MODE_REVERSE   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         position;
    } in_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  item_value;
        logic [LEN_W-1:0]         length;
        logic                     last;
    } out_item_t;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_REVERSE,
        OP_ROTATE
    } dp_op_t;

    typedef struct packed {
        dp_op_t                   op;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  value;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic signed [VAL_W-1:0]  front;
        logic signed [VAL_W-1:0]  sel;
    } dp_stat_t;

    typedef enum logic {
        ST_IDLE,
        ST_ROT
    } state_t;

endpackage

// ===== rtl/core/ple_datapath.sv =====
// Chain of element cells with shift, reverse and rotate moves, plus the count.
// Depends on ple_pkg.
module ple_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ple_pkg::dp_cmd_t  dp_cmd,
    output ple_pkg::dp_stat_t dp_stat
);

    logic signed [ple_pkg::VAL_W-1:0] cells_reg  [ple_pkg::DEPTH];
    logic signed [ple_pkg::VAL_W-1:0] cells_next [ple_pkg::DEPTH];
    logic [ple_pkg::CNT_W-1:0]        count_reg;
    logic [ple_pkg::CNT_W-1:0]        count_next;

    // Select each cell's next value from its neighbors, its mirror cell or the command value
    for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
        localparam logic [ple_pkg::IDX_W-1:0] MY_IDX = ple_pkg::IDX_W'(i);
        localparam int MIRROR = ple_pkg::DEPTH - 1 - i;
        localparam int UP     = (i + 1) % ple_pkg::DEPTH;
        logic signed [ple_pkg::VAL_W-1:0] below;
        logic signed [ple_pkg::VAL_W-1:0] above;

        if (i > 0) begin : g_below
            assign below = cells_reg[i-1];
        end
        else begin : g_front
            assign below = cells_reg[0];
        end

        if (i < ple_pkg::DEPTH - 1) begin : g_above
            assign above = cells_reg[i+1];
        end
        else begin : g_back
            assign above = cells_reg[i];
        end

        always_comb
        begin
            cells_next[i] = cells_reg[i];
            case (dp_cmd.op)
                ple_pkg::OP_INSERT:
                begin
                    if (MY_IDX == dp_cmd.idx)
                        cells_next[i] = dp_cmd.value;
                    else if (MY_IDX > dp_cmd.idx)
                        cells_next[i] = below;
                end
                ple_pkg::OP_DELETE:
                begin
                    if (MY_IDX >= dp_cmd.idx)
                        cells_next[i] = above;
                end
                ple_pkg::OP_REVERSE: cells_next[i] = cells_reg[MIRROR];
                ple_pkg::OP_ROTATE:  cells_next[i] = cells_reg[UP];
                default:             cells_next[i] = cells_reg[i];
            endcase
        end
    end

    // Advance the element count
    always_comb
    begin
        case (dp_cmd.op)
            ple_pkg::OP_INSERT: count_next = count_reg + 1'b1;
            ple_pkg::OP_DELETE: count_next = count_reg - 1'b1;
            default:            count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign dp_stat.count = count_reg;
    assign dp_stat.front = cells_reg[0];
    assign dp_stat.sel   = cells_reg[dp_cmd.idx];

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == ple_pkg::OP_INSERT |-> count_reg < ple_pkg::CNT_W'(ple_pkg::DEPTH))
        else $error("insert issued into a full chain");

    a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == ple_pkg::OP_DELETE |-> count_reg != '0)
        else $error("delete issued on an empty chain");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
        else $error("element count beyond depth");

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// Command decode, rotation sequencer and result register for the list engine.
// Depends on ple_pkg; drives ple_datapath through dp_cmd_t.
module ple_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ple_pkg::in_item_t   cmd,
    output logic                busy,
    output logic                done,
    output ple_pkg::out_item_t  result,
    output ple_pkg::dp_cmd_t    dp_cmd,
    input  ple_pkg::dp_stat_t   dp_stat
);

    ple_pkg::state_t             state_reg, state_next;
    logic [ple_pkg::IDX_W-1:0]   rot_reg, rot_next;
    logic                        done_reg, done_next;
    ple_pkg::out_item_t          result_reg, result_next;

    logic [ple_pkg::CNT_W-1:0]   cnt;
    logic                        full, empty;
    logic [ple_pkg::POS_W:0]     pos_x;
    logic [ple_pkg::POS_W:0]     cnt_x;
    logic                        ins_pos_ok, del_pos_ok;
    logic [ple_pkg::IDX_W-1:0]   pos_idx;
    logic [ple_pkg::LEN_W-1:0]   len_now, len_inc, len_dec;
    logic [ple_pkg::CNT_W-1:0]   rot_x;

    assign cnt        = dp_stat.count;
    assign full       = cnt == ple_pkg::CNT_W'(ple_pkg::DEPTH);
    assign empty      = cnt == '0;
    assign pos_x      = {1'b0, cmd.position};
    assign cnt_x      = (ple_pkg::POS_W+1)'(cnt);
    assign ins_pos_ok = pos_x != '0 && pos_x <= cnt_x + 1'b1;
    assign del_pos_ok = pos_x != '0 && pos_x <= cnt_x;
    assign pos_idx    = ple_pkg::IDX_W'(cmd.position - 1'b1);
    assign len_now    = ple_pkg::LEN_W'(cnt);
    assign len_inc    = len_now + 1'b1;
    assign len_dec    = len_now - 1'b1;
    assign rot_x      = ple_pkg::CNT_W'(rot_reg);

    // Decode commands, sequence rotations and form the next result
    always_comb
    begin
        state_next         = state_reg;
        rot_next           = rot_reg;
        done_next          = 1'b0;
        result_next        = result_reg;
        dp_cmd.op          = ple_pkg::OP_NONE;
        dp_cmd.idx         = '0;
        dp_cmd.value       = cmd.value;

        case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    done_next              = 1'b1;
                    result_next.status     = ple_pkg::STAT_OK;
                    result_next.item_value = '0;
                    result_next.length     = len_now;
                    result_next.last       = 1'b1;
                    case (cmd.mode)
                        ple_pkg::MODE_INS_END, ple_pkg::MODE_INS_FRONT,
                        ple_pkg::MODE_INS_POS:
                        begin
                            if (cmd.mode == ple_pkg::MODE_INS_END)
                                dp_cmd.idx = ple_pkg::IDX_W'(cnt);
                            else if (cmd.mode == ple_pkg::MODE_INS_POS)
                                dp_cmd.idx = pos_idx;
                            if (full)
                                result_next.status = ple_pkg::STAT_FULL;
                            else if (cmd.mode == ple_pkg::MODE_INS_POS && !ins_pos_ok)
                                result_next.status = ple_pkg::STAT_INVALID;
                            else
                            begin
                                dp_cmd.op          = ple_pkg::OP_INSERT;
                                result_next.length = len_inc;
                            end
                        end
                        ple_pkg::MODE_DEL_END, ple_pkg::MODE_DEL_FRONT,
                        ple_pkg::MODE_DEL_POS:
                        begin
                            if (cmd.mode == ple_pkg::MODE_DEL_END)
                                dp_cmd.idx = ple_pkg::IDX_W'(cnt - 1'b1);
                            else if (cmd.mode == ple_pkg::MODE_DEL_POS)
                                dp_cmd.idx = pos_idx;
                            if (empty)
                                result_next.status = ple_pkg::STAT_EMPTY;
                            else if (cmd.mode == ple_pkg::MODE_DEL_POS && !del_pos_ok)
                                result_next.status = ple_pkg::STAT_INVALID;
                            else
                            begin
                                dp_cmd.op              = ple_pkg::OP_DELETE;
                                result_next.item_value = dp_stat.sel;
                                result_next.length     = len_dec;
                            end
                        end
                        ple_pkg::MODE_READ:
                        begin
                            if (empty)
                                result_next.status = ple_pkg::STAT_EMPTY;
                            else
                            begin
                                // Results come out of the rotation pass
                                done_next  = 1'b0;
                                rot_next   = '0;
                                state_next = ple_pkg::ST_ROT;
                            end
                        end
                        ple_pkg::MODE_REVERSE:
                        begin
                            // Mirror the whole chain, then rotate the block back to the front
                            if (cnt > ple_pkg::CNT_W'(1))
                            begin
                                dp_cmd.op = ple_pkg::OP_REVERSE;
                                if (!full)
                                begin
                                    rot_next   = ple_pkg::IDX_W'(cnt);
                                    state_next = ple_pkg::ST_ROT;
                                end
                            end
                        end
                        default: result_next.status = ple_pkg::STAT_OK;
                    endcase
                end
            end
            ple_pkg::ST_ROT:
            begin
                dp_cmd.op = ple_pkg::OP_ROTATE;
                if (rot_x < cnt)
                begin
                    done_next              = 1'b1;
                    result_next.status     = ple_pkg::STAT_OK;
                    result_next.item_value = dp_stat.front;
                    result_next.length     = len_now;
                    result_next.last       = rot_x == cnt - 1'b1;
                end
                if (rot_reg == ple_pkg::IDX_W'(ple_pkg::DEPTH - 1))
                    state_next = ple_pkg::ST_IDLE;
                else
                    rot_next = rot_reg + 1'b1;
            end
            default: state_next = ple_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::ST_IDLE;
            rot_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rot_reg   <= rot_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = state_reg != ple_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    a_len_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> result_reg.length == ple_pkg::LEN_W'(dp_stat.count))
        else $error("result length differs from element count");

    a_rot_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ple_pkg::ST_ROT |-> dp_stat.count != '0)
        else $error("rotation pass on an empty list");

    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ple_pkg::ST_IDLE && start && cmd.mode == ple_pkg::MODE_READ
         && dp_stat.count != '0) |=> ##1 done_reg)
        else $error("read did not emit its first element");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.last) |-> state_reg == ple_pkg::ST_ROT)
        else $error("non-final result outside a read pass");

endmodule

// ===== rtl/core/positional_list_engine_core.sv =====
// Top level of the positional list engine: controller plus cell datapath.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
//
// A command transfers when start is high and busy is low. For insert, delete, a
// read of an empty list and a reverse of a full list or of at most one element,
// the result shows on result with done high in the cycle after the transfer, and
// a new command may transfer in that same cycle. A read of a non-empty list
// rotates the cell chain once per cycle through one full turn and captures the
// front cell before each of its first count rotations; from the rotation state
// its count results are registered onto result one per cycle, and the next
// command can transfer once the turn has ended. A reverse of two to DEPTH - 1
// elements mirrors the chain and then rotates the elements back to the front;
// its single result still shows in the cycle after the transfer, and the next
// command can transfer once that rotation has ended. Busy stays high through
// these passes. done is a one-cycle strobe: the receiver must take each result
// in the cycle it appears.
module positional_list_engine_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ple_pkg::in_item_t   cmd,
    output logic                busy,
    output logic                done,
    output ple_pkg::out_item_t  result
);

    ple_pkg::dp_cmd_t  dp_cmd;
    ple_pkg::dp_stat_t dp_stat;

    ple_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    ple_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for positional_list_engine_core: directed table, then random commands.
// Depends on ple_pkg and the positional_list_engine_core RTL; needs no other files.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_CMDS  = 266;
    localparam int TAIL_CYCLES  = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT  = 250000;

    // One expected result, stamped with the edge at which its command transferred
    typedef struct {
        out_item_t res;
        time       issued;
    } due_result_t;

    // One row of the directed table; reps repeats the command with value + k
    typedef struct {
        in_item_t  cmd;
        int        reps;
        bit        pinned;
        out_item_t pin_res;
    } cmd_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  cmd   = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    // Shadow copy of the list and the results still owed by the block
    logic signed [VAL_W-1:0] list_cells [DEPTH];
    int                      list_len = 0;
    out_item_t               fresh_results [$];
    due_result_t             pending_results [$];
    cmd_row_t                dir_rows [$];

    int  errors       = 0;
    int  cycle_count  = 0;
    int  calm_left    = 0;
    bit  grow         = 1'b1;
    int  cmds_sent    = 0;
    int  results_seen = 0;
    int  n_full       = 0;
    int  n_empty      = 0;
    int  n_invalid    = 0;
    int  n_reads      = 0;

    positional_list_engine_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("positional_list_engine_core: mismatch");
            $finish;
        end
    end

    // Work out the results of one command and advance the shadow list
    task automatic apply_list_cmd(in_item_t c);
        int                      idx;
        int                      j;
        int                      a;
        int                      b;
        logic signed [VAL_W-1:0] tmp;
        out_item_t               r;
        fresh_results.delete();
        r        = '0;
        r.status = STAT_OK;
        r.last   = 1'b1;
        case (c.mode)
            MODE_INS_END, MODE_INS_FRONT, MODE_INS_POS:
            begin
                if (list_len >= DEPTH)
                    r.status = STAT_FULL;
                else if (c.mode == MODE_INS_POS &&
                         (c.position == 0 || int'(c.position) > list_len + 1))
                    r.status = STAT_INVALID;
                else
                begin
                    if (c.mode == MODE_INS_END)
                        idx = list_len;
                    else if (c.mode == MODE_INS_FRONT)
                        idx = 0;
                    else
                        idx = int'(c.position) - 1;
                    for (j = list_len; j > idx; j--)
                        list_cells[j] = list_cells[j-1];
                    list_cells[idx] = c.value;
                    list_len++;
                end
            end
            MODE_DEL_END, MODE_DEL_FRONT, MODE_DEL_POS:
            begin
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else if (c.mode == MODE_DEL_POS &&
                         (c.position == 0 || int'(c.position) > list_len))
                    r.status = STAT_INVALID;
                else
                begin
                    if (c.mode == MODE_DEL_END)
                        idx = list_len - 1;
                    else if (c.mode == MODE_DEL_FRONT)
                        idx = 0;
                    else
                        idx = int'(c.position) - 1;
                    r.item_value = list_cells[idx];
                    for (j = idx; j + 1 < list_len; j++)
                        list_cells[j] = list_cells[j+1];
                    list_len--;
                end
            end
            MODE_READ:
            begin
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // Emit every element front first, last flag on the final one
                    for (j = 0; j < list_len; j++)
                    begin
                        r.item_value = list_cells[j];
                        r.length     = LEN_W'(list_len);
                        r.last       = (j + 1 == list_len);
                        fresh_results.push_back(r);
                    end
                    return;
                end
            end
            MODE_REVERSE:
            begin
                a = 0;
                b = list_len - 1;
                while (a < b)
                begin
                    tmp           = list_cells[a];
                    list_cells[a] = list_cells[b];
                    list_cells[b] = tmp;
                    a++;
                    b--;
                end
            end
        endcase
        r.length = LEN_W'(list_len);
        fresh_results.push_back(r);
    endtask

    // Check each strobed result against the oldest one owed
    always @(posedge clk)
    begin
        due_result_t d;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0 || pending_results[0].issued >= $time)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d value=%0d length=%0d last=%0d",
                         $time, result.status, result.item_value, result.length,
                         result.last);
            end
            else
            begin
                d = pending_results.pop_front();
                if (result.status !== d.res.status || result.item_value !== d.res.item_value ||
                    result.length !== d.res.length || result.last !== d.res.last)
                begin
                    errors++;
                    $display("%0t: expected status=%0d value=%0d length=%0d last=%0d",
                             $time, d.res.status, d.res.item_value, d.res.length,
                             d.res.last);
                    $display("%0t:   actual status=%0d value=%0d length=%0d last=%0d",
                             $time, result.status, result.item_value, result.length,
                             result.last);
                end
            end
        end
    end

    // Choose an idle gap before the next transfer: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm_left = $urandom_range(10, 30);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Drive one command, hold it until it transfers, then record what it owes
    task automatic send_cmd(in_item_t c, bit pinned, out_item_t pin_res);
        int          gap;
        due_result_t d;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_list_cmd(c);
        if (pinned)
        begin
            fresh_results.delete();
            fresh_results.push_back(pin_res);
        end
        foreach (fresh_results[i])
        begin
            d.res    = fresh_results[i];
            d.issued = $time;
            pending_results.push_back(d);
            case (fresh_results[i].status)
                STAT_FULL:    n_full++;
                STAT_EMPTY:   n_empty++;
                STAT_INVALID: n_invalid++;
                default:      ;
            endcase
        end
        if (c.mode == MODE_READ)
            n_reads++;
        cmds_sent++;
    endtask

    // Hold off until every owed result has come
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic void add_row(mode_t m, logic [VAL_W-1:0] v, logic [POS_W-1:0] p,
                                    int reps, bit pin, status_t s, int len);
        cmd_row_t row;
        row.cmd.mode            = m;
        row.cmd.value           = v;
        row.cmd.position        = p;
        row.reps                = reps;
        row.pinned              = pin;
        row.pin_res             = '0;
        row.pin_res.status      = s;
        row.pin_res.length      = LEN_W'(len);
        row.pin_res.last        = 1'b1;
        dir_rows.push_back(row);
    endfunction

    // Build a random command, leaning toward growth or shrinkage by phase
    function automatic in_item_t rand_cmd();
        in_item_t c;
        int       r;
        if (list_len >= DEPTH)
            grow = 1'b0;
        else if (list_len == 0)
            grow = 1'b1;
        else if ($urandom_range(0, 39) == 0)
            grow = ~grow;
        r = $urandom_range(0, 99);
        if (r < 10)
            c.mode = MODE_READ;
        else if (r < 17)
            c.mode = MODE_REVERSE;
        else if (r < (grow ? 75 : 42))
            c.mode = mode_t'($urandom_range(MODE_INS_END, MODE_INS_POS));
        else
            c.mode = mode_t'($urandom_range(MODE_DEL_END, MODE_DEL_POS));
        r = $urandom_range(0, 9);
        if (r < 7)
            c.value = $urandom;
        else if (r == 7)
            c.value = 32'h7FFF_FFFF;
        else if (r == 8)
            c.value = 32'h8000_0000;
        else
            c.value = $urandom_range(0, 15);
        r = $urandom_range(0, 9);
        if (r < 8 && c.mode == MODE_INS_POS)
            c.position = POS_W'($urandom_range(1, list_len + 1));
        else if (r < 8 && c.mode == MODE_DEL_POS && list_len > 0)
            c.position = POS_W'($urandom_range(1, list_len));
        else if (r == 8)
            c.position = '0;
        else
            c.position = POS_W'($urandom_range(0, 255));
        return c;
    endfunction

    initial
    begin
        in_item_t c;
        // Empty list: every special case that reports empty or invalid, and a reverse
        add_row(MODE_READ,      32'h0,         8'd0,   1,  1, STAT_EMPTY,   0);
        add_row(MODE_DEL_END,   32'h0,         8'd0,   1,  1, STAT_EMPTY,   0);
        add_row(MODE_DEL_FRONT, 32'h0,         8'd0,   1,  1, STAT_EMPTY,   0);
        add_row(MODE_DEL_POS,   32'h0,         8'd0,   1,  1, STAT_EMPTY,   0);
        add_row(MODE_REVERSE,   32'h0,         8'd0,   1,  1, STAT_OK,      0);
        add_row(MODE_INS_POS,   32'h1,         8'd0,   1,  1, STAT_INVALID, 0);
        add_row(MODE_INS_POS,   32'h1,         8'd2,   1,  1, STAT_INVALID, 0);
        // Single element, value extremes, position edges
        add_row(MODE_INS_POS,   32'h7FFF_FFFF, 8'd1,   1,  1, STAT_OK,      1);
        add_row(MODE_REVERSE,   32'h0,         8'd0,   1,  1, STAT_OK,      1);
        add_row(MODE_DEL_POS,   32'h0,         8'd2,   1,  1, STAT_INVALID, 1);
        add_row(MODE_READ,      32'h0,         8'd0,   1,  0, STAT_OK,      0);
        add_row(MODE_INS_FRONT, 32'h8000_0000, 8'd0,   1,  1, STAT_OK,      2);
        add_row(MODE_INS_END,   32'hFFFF_FFFF, 8'd0,   1,  1, STAT_OK,      3);
        add_row(MODE_INS_POS,   32'h0,         8'd255, 1,  1, STAT_INVALID, 3);
        add_row(MODE_INS_POS,   32'h5555_5555, 8'd4,   1,  1, STAT_OK,      4);
        add_row(MODE_INS_POS,   32'hAAAA_AAAA, 8'd2,   1,  0, STAT_OK,      0);
        add_row(MODE_REVERSE,   32'h0,         8'd0,   1,  0, STAT_OK,      0);
        add_row(MODE_READ,      32'h0,         8'd0,   1,  0, STAT_OK,      0);
        add_row(MODE_DEL_POS,   32'h0,         8'd5,   1,  0, STAT_OK,      0);
        add_row(MODE_DEL_FRONT, 32'h0,         8'd0,   1,  0, STAT_OK,      0);
        add_row(MODE_DEL_END,   32'h0,         8'd0,   1,  0, STAT_OK,      0);
        // Fill to capacity, then hit the full and out-of-range cases
        add_row(MODE_INS_END,   32'h0000_1000, 8'd0,   14, 0, STAT_OK,      0);
        add_row(MODE_INS_END,   32'h1,         8'd0,   1,  1, STAT_FULL,    DEPTH);
        add_row(MODE_INS_FRONT, 32'h1,         8'd0,   1,  1, STAT_FULL,    DEPTH);
        add_row(MODE_INS_POS,   32'h1,         8'd0,   1,  1, STAT_FULL,    DEPTH);
        add_row(MODE_DEL_POS,   32'h0,         8'd0,   1,  1, STAT_INVALID, DEPTH);
        add_row(MODE_DEL_POS,   32'h0,         8'd17,  1,  1, STAT_INVALID, DEPTH);
        add_row(MODE_REVERSE,   32'h0,         8'd0,   1,  0, STAT_OK,      0);
        add_row(MODE_READ,      32'h0,         8'd0,   1,  0, STAT_OK,      0);
        add_row(MODE_DEL_POS,   32'h0,         8'd16,  1,  0, STAT_OK,      0);
        add_row(MODE_INS_POS,   32'h1234_5678, 8'd16,  1,  0, STAT_OK,      0);

        // Hold reset, release it on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[r])
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
            begin
                c       = dir_rows[r].cmd;
                c.value = dir_rows[r].cmd.value + k;
                send_cmd(c, dir_rows[r].pinned, dir_rows[r].pin_res);
            end
        end
        drain_results();

        // Random commands, with an occasional full drain
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if ($urandom_range(0, 29) == 0)
                drain_results();
            send_cmd(rand_cmd(), 1'b0, '0);
        end
        start <= 1'b0;

        // Wait out the owed results and let any stray strobe show
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors += pending_results.size();
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Sent %0d commands (%0d reads), checked %0d results, %0d errors.",
                 cmds_sent, n_reads, results_seen, errors);
        $display("Status hits: full %0d, empty %0d, invalid position %0d.",
                 n_full, n_empty, n_invalid);
        if (errors == 0)
            $display("positional_list_engine_core: match");
        else
            $display("positional_list_engine_core: mismatch");
        $finish;
    end

endmodule
